FILE: rtl/core/red_neighbour_count_filter_unit_assert.svh
// Assertion macros shared by the red neighbour count filter checker.
`ifndef RED_NEIGHBOUR_COUNT_FILTER_UNIT_ASSERT_SVH
`define RED_NEIGHBOUR_COUNT_FILTER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define RNCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RNCF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/rncf_pkg.sv
// Shared types and constants of the red neighbour count filter.
`default_nettype none

package rncf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MIN_SIZE       = 3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int PIX_W       = 8;
	localparam int THR_W       = 4;
	localparam int COORD_W     = 10;
	localparam int WIN_ROWS    = 3;

	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam logic [PIX_W-1:0] RED_LEVEL_RST = 8'd255;
	localparam logic [THR_W-1:0] MIN_NB_RST    = 4'd7;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH        = 2'd0,
		REG_IMAGE_HEIGHT       = 2'd1,
		REG_RED_LEVEL          = 2'd2,
		REG_MIN_RED_NEIGHBOURS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] centre_x;
		logic [COORD_W-1:0] centre_y;
		logic               mark_red;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rncf_line_store.sv
// Two-row line store of red bits with a fill count standing in for the reset clear.
`default_nettype none

module rncf_line_store #(
	parameter int DEPTH = rncf_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [1:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [1:0]               wr_data
);
	import rncf_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);

	// bit 0: row two above, bit 1: row just above
	logic [1:0]    mem_q [DEPTH];
	logic [1:0]    rd_q;
	logic          hit_q;
	logic [FW-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Columns are visited as a growing prefix, so everything below fill_q has been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (wr_en && (FW'(wr_addr) >= fill_q)) begin
				fill_q <= FW'(wr_addr) + FW'(1);
			end
			if (rd_en) begin
				hit_q <= FW'(rd_addr) < fill_q;
			end
		end
	end

	assign rd_data = hit_q ? rd_q : 2'b00;

endmodule

`default_nettype wire

FILE: rtl/core/rncf_cell.sv
// One column cell of the 3x3 window: holds three red bits, passes them on each shift.
`default_nettype none

module rncf_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [rncf_pkg::WIN_ROWS-1:0] col_in,
	output logic [rncf_pkg::WIN_ROWS-1:0] col_q
);
	import rncf_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= col_in;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rncf_out_queue.sv
// Two-entry result queue that decouples the window stage from the output stall.
`default_nettype none

module rncf_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rncf_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output rncf_pkg::result_t out_data
);
	import rncf_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign pop       = out_valid && !out_stall;
	assign out_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/red_neighbour_count_filter_unit.sv
// A result is formed while its completing pixel sits in the stage-one registers, then queued.
// Throughput: one pixel per cycle unless stalled; one line store read and one write per pixel.
// Input stalls only once both entries of the result queue hold results that are not taken.
// Reset (asynchronous): position, window and queue clear, registers return to 640/480/255/7.
// The line store needs no clearing pass after reset; its fill count clears in the same cycle.
`default_nettype none

module red_neighbour_count_filter_unit #(
	parameter int MAX_WIDTH  = rncf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rncf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rncf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rncf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rncf_pkg::PIX_W-1:0]       pixel_red,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rncf_pkg::COORD_W-1:0]     centre_x,
	output logic [rncf_pkg::COORD_W-1:0]     centre_y,
	output logic                             mark_red
);
	import rncf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WW    = COL_W + 1;
	localparam int HW    = ROW_W + 1;

	// configuration, sizes stored already clamped
	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [PIX_W-1:0] red_level_q;
	logic [THR_W-1:0] min_nb_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             col_wrap;
	logic [HW-1:0]    row_inc;
	logic [COL_W-1:0] x0;
	logic [ROW_W-1:0] y0;
	logic [WW-1:0]    col_nx;
	logic [HW-1:0]    row_nx;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic             accept;

	logic             valid_s1;
	logic [COL_W-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;
	logic             red_s1;
	logic             s1_go;

	logic [1:0]          ls_rd;
	logic [WIN_ROWS-1:0] col_w [3];
	logic [7:0]          nb;
	logic [THR_W-1:0]    nb_cnt;
	logic [COL_W-1:0]    xm1;
	logic [ROW_W-1:0]    ym1;
	logic                q_full;
	logic                push;
	result_t             res;
	result_t             out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= WW'(WIDTH_RST);
			h_q         <= HW'(HEIGHT_RST);
			red_level_q <= RED_LEVEL_RST;
			min_nb_q    <= MIN_NB_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					if (int'(cfg_data) < MIN_SIZE) begin
						w_q <= WW'(MIN_SIZE);
					end else if (int'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (int'(cfg_data) < MIN_SIZE) begin
						h_q <= HW'(MIN_SIZE);
					end else if (int'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
				end
				REG_RED_LEVEL:          red_level_q <= cfg_data[PIX_W-1:0];
				REG_MIN_RED_NEIGHBOURS: min_nb_q    <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Position of this pixel: wrap first in case the size shrank, then step to the next one.
	always_comb begin
		col_wrap = {1'b0, col_q} >= w_q;
		row_inc  = {1'b0, row_q} + HW'(col_wrap);
		x0       = col_wrap ? '0 : col_q;
		y0       = (row_inc >= h_q) ? '0 : row_inc[ROW_W-1:0];
		col_nx   = {1'b0, x0} + WW'(1);
		if (col_nx >= w_q) begin
			col_n  = '0;
			row_nx = {1'b0, y0} + HW'(1);
		end else begin
			col_n  = col_nx[COL_W-1:0];
			row_nx = {1'b0, y0};
		end
		row_n = (row_nx >= h_q) ? '0 : row_nx[ROW_W-1:0];
	end

	assign s1_go    = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			col_q    <= col_n;
			row_q    <= row_n;
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= x0;
			y_s1   <= y0;
			red_s1 <= pixel_red == red_level_q;
		end
	end

	rncf_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (x0),
		.rd_data (ls_rd),
		.wr_en   (s1_go),
		.wr_addr (x_s1),
		.wr_data ({red_s1, ls_rd[1]})
	);

	// Newest column enters at the right; it is held in no cell but formed from red_s1 and the line store.
	assign col_w[2] = {red_s1, ls_rd[1], ls_rd[0]};

	for (genvar i = 0; i < 2; i++) begin : g_cell
		rncf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (s1_go),
			.col_in (col_w[i+1]),
			.col_q  (col_w[i])
		);
	end

	// col_w[1] is the centre column of the window being judged
	assign nb = {col_w[2], col_w[1][2], col_w[1][0], col_w[0]};

	always_comb begin
		nb_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			nb_cnt = nb_cnt + THR_W'(nb[i]);
		end
	end

	assign xm1  = x_s1 - COL_W'(1);
	assign ym1  = y_s1 - ROW_W'(1);
	assign push = s1_go && (x_s1 >= COL_W'(2)) && (y_s1 >= ROW_W'(2));

	always_comb begin
		res.centre_x = COORD_W'(xm1);
		res.centre_y = COORD_W'(ym1);
		res.mark_red = col_w[1][1] && (nb_cnt >= min_nb_q);
	end

	rncf_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign centre_x = out_res.centre_x;
	assign centre_y = out_res.centre_y;
	assign mark_red = out_res.mark_red;

endmodule

`default_nettype wire

FILE: rtl/core/rncf_checker.sv
// Port-level checker for the red neighbour count filter, bound to the top level.
`default_nettype none

`include "red_neighbour_count_filter_unit_assert.svh"

module rncf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [rncf_pkg::COORD_W-1:0] centre_x,
	input logic [rncf_pkg::COORD_W-1:0] centre_y,
	input logic                         mark_red
);
	import rncf_pkg::*;

	// input only backs up when a result is waiting downstream
	`RNCF_ASSERT(a_stall_needs_backlog, in_stall |-> out_valid, "input stalled with no result pending")

	// border pixels never produce a result
	`RNCF_ASSERT(a_interior_only, out_valid |-> (centre_x != 10'd0) && (centre_y != 10'd0), "result on border")

	`RNCF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(centre_x) && $stable(centre_y) && $stable(mark_red), "stalled result changed")

	// registers clear asynchronously when reset asserts; the check looks at the edge after reset is sampled
	`RNCF_ASSERT_RST(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "activity during reset")

endmodule

bind red_neighbour_count_filter_unit rncf_checker u_rncf_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the red neighbour count filter unit.
module testbench;
	import rncf_pkg::*;

	localparam int LINE_MAX = MAX_WIDTH_DEF;
	localparam int ROWS_MAX = MAX_HEIGHT_DEF;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_PIXELS = 870;
	localparam int PLAN_LEN = 26;
	localparam longint CYCLE_LIMIT = 1200000;

	typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] value;
		logic                  fixed;
		result_t               want;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_red = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_W-1:0]    centre_x;
	logic [COORD_W-1:0]    centre_y;
	logic                  mark_red;

	// mirror of the block's registers and window state
	logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(WIDTH_RST);
	logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RST);
	logic [PIX_W-1:0]      level_reg = RED_LEVEL_RST;
	logic [THR_W-1:0]      min_nb_reg = MIN_NB_RST;
	bit [LINE_MAX-1:0]     upper_row = '0;
	bit [LINE_MAX-1:0]     middle_row = '0;
	bit [8:0]              window = '0;
	int unsigned           col_pos = 0;
	int unsigned           row_pos = 0;

	result_t     pending_marks [$];
	int unsigned mark_errors = 0;
	longint      cycle_count = 0;
	bit          steady = 1'b0;
	int unsigned sink_left = 0;

	// directed sequence: 3 wide, height clamped to max, then threshold and level changes
	step_t plan [PLAN_LEN] = '{
		'{STEP_REG, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_REG, REG_IMAGE_HEIGHT, 11'd2047, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b1, '{10'd1, 10'd1, 1'b1}},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b1, '{10'd1, 10'd2, 1'b0}},
		'{STEP_REG, REG_MIN_RED_NEIGHBOURS, 11'd0, 1'b0, '0},
		'{STEP_REG, REG_RED_LEVEL, 11'd0, 1'b0, '0},
		// stored bits keep the old level: row 3 centre stays red
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b1, '{10'd1, 10'd3, 1'b1}},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd255, 1'b1, '{10'd1, 10'd4, 1'b1}},
		'{STEP_REG, REG_MIN_RED_NEIGHBOURS, 11'd15, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH, 11'd0, 1'b1, '{10'd1, 10'd5, 1'b0}}
	};

	red_neighbour_count_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_red (pixel_red),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.centre_x  (centre_x),
		.centre_y  (centre_y),
		.mark_red  (mark_red)
	);

	always #1 clk = ~clk;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void wrap_position(input int unsigned w, input int unsigned h);
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
	endfunction

	// shifts one pixel into the window; returns 1 when an interior centre is judged
	function automatic bit judge_pixel(input logic [PIX_W-1:0] value, output result_t res);
		int unsigned w, h, x, y, nb;
		bit red, hit;
		bit [2:0] column;
		w = clamp_dim(width_reg, LINE_MAX);
		h = clamp_dim(height_reg, ROWS_MAX);
		res = '0;
		hit = 1'b0;
		wrap_position(w, h);
		x = col_pos;
		y = row_pos;
		if (x >= LINE_MAX) x = 0;
		red = (value == level_reg);
		column = {red, middle_row[x], upper_row[x]};
		window = {column, window[8:3]};
		upper_row[x] = middle_row[x];
		middle_row[x] = red;
		if (x >= 2 && y >= 2) begin
			// eight neighbours, centre bit masked out
			nb = $countones(window & 9'h1EF);
			res.centre_x = COORD_W'(x - 1);
			res.centre_y = COORD_W'(y - 1);
			res.mark_red = window[4] && (nb >= min_nb_reg);
			hit = 1'b1;
		end
		col_pos = x + 1;
		wrap_position(w, h);
		return hit;
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_IMAGE_WIDTH: width_reg = value;
			REG_IMAGE_HEIGHT: height_reg = value;
			REG_RED_LEVEL: level_reg = value[PIX_W-1:0];
			REG_MIN_RED_NEIGHBOURS: min_nb_reg = value[THR_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return CFG_DATA_W'($urandom_range(3, 10));
		if (r == 7) return CFG_DATA_W'($urandom_range(11, 40));
		case ($urandom_range(0, 5))
			0: return 11'd0;
			1: return 11'd1;
			2: return 11'd2;
			3: return 11'd1024;
			4: return 11'd1025;
			default: return 11'd2047;
		endcase
	endfunction

	// waits until the block has delivered everything and gone quiet
	task automatic settle();
		in_valid = 1'b0;
		while (pending_marks.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] value, input bit fixed, input result_t want);
		result_t res;
		int unsigned gap;
		if (!steady && $urandom_range(0, 2) == 0) begin
			gap = idle_len();
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		pixel_red = value;
		do @(posedge clk); while (in_stall);
		if (judge_pixel(value, res)) pending_marks.push_back(fixed ? want : res);
		@(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] random_pixel();
		if ($urandom_range(0, 3) != 0) return level_reg;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// receiver: alternating stall and free runs, some of them long
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall = 1'b0;
		end else if (sink_left != 0) begin
			sink_left--;
		end else begin
			out_stall = ~out_stall;
			if (out_stall)
				sink_left = idle_len();
			else
				sink_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 6);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {centre_x, centre_y, mark_red};
			if (pending_marks.size() == 0) begin
				mark_errors++;
				if (mark_errors <= 10)
					$display("unexpected transfer: x=%0d y=%0d mark=%0d",
						got.centre_x, got.centre_y, got.mark_red);
			end else begin
				want = pending_marks.pop_front();
				if (got.centre_x != want.centre_x || got.centre_y != want.centre_y ||
						got.mark_red != want.mark_red) begin
					mark_errors++;
					if (mark_errors <= 10)
						$display("mismatch: expected x=%0d y=%0d mark=%0d, got x=%0d y=%0d mark=%0d",
							want.centre_x, want.centre_y, want.mark_red,
							got.centre_x, got.centre_y, got.mark_red);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("red_neighbour_count_filter_unit test failed");
			$finish;
		end
	end

	initial begin
		int unsigned sent, burst, thr;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG)
				write_reg(plan[i].idx, plan[i].value);
			else
				send_pixel(plan[i].value[PIX_W-1:0], plan[i].fixed, plan[i].want);
		end

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_dim());
			if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, pick_dim());
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_RED_LEVEL, $urandom_range(0, 1) ? 11'd255 : 11'd0);
			else if ($urandom_range(0, 1))
				write_reg(REG_RED_LEVEL, CFG_DATA_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) begin
				thr = $urandom_range(0, 15);
				if (thr > 8 && $urandom_range(0, 2) != 0) thr = $urandom_range(5, 8);
				write_reg(REG_MIN_RED_NEIGHBOURS, CFG_DATA_W'(thr));
			end
			steady = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(20, 150);
			repeat (burst) send_pixel(random_pixel(), 1'b0, '0);
			sent += burst;
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mark_errors == 0 && pending_marks.size() == 0)
			$display("red_neighbour_count_filter_unit test passed");
		else
			$display("red_neighbour_count_filter_unit test failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rncf_pkg.sv
rtl/core/rncf_line_store.sv
rtl/core/rncf_cell.sv
rtl/core/rncf_out_queue.sv
rtl/core/red_neighbour_count_filter_unit.sv
rtl/core/rncf_checker.sv
sim/testbench.sv
